/* rtl/aed_pkg.sv */
`timescale 1ns / 1ps

package aed_pkg;

  localparam int POLE_W = 16;
  localparam int COEF_W = 16;
  localparam int AUDIO_W = 18;
  localparam int FB_W = AUDIO_W + 1;

  localparam logic [COEF_W-1:0] ALPHA_Q16 = 16'd62098;
  localparam logic [COEF_W-1:0] BETA_Q16 = 16'd25722;
  localparam logic [POLE_W-1:0] POLE_RESET = 16'd65208;

  localparam int ROUND_HALF = 32768;
  localparam int AUDIO_MAX = 131071;
  localparam int AUDIO_MIN = -131072;

endpackage

/* rtl/am_envelope_dc_block_core.sv */
`timescale 1ns / 1ps

// AM envelope detector with DC blocker.
// Input queue side: present in_i/in_q with push; a request is taken at a
// clock edge where push is high and full is low. Up to one request per cycle.
// Result queue side: while empty is low, audio holds the oldest result; it
// is removed at an edge where pop is high. One result per request, in order.
// A request taken passes three magnitude stages, the magnitude queue and
// the result queue before it is visible on audio.
// Throughput: one request per cycle while the result queue is drained; the
// DC blocker recursion (one 17x18 multiply, add, saturate) sets that limit.
// When pop is held low the result queue fills, the back end stops, the
// magnitude queue and then the front stages fill, and full rises; nothing
// is dropped. cfg_wr_en/cfg_wr_data write the blocker pole (Q0.16); the
// user writes it only while the block is idle, not enforced by the block.
// Reset (rst, synchronous): queues empty, blocker history cleared, pole set
// to 0.995. The block takes requests in the cycle after reset drops.
module am_envelope_dc_block_core #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [aed_pkg::POLE_W-1:0]  cfg_wr_data,
  input  logic                        push,
  output logic                        full,
  input  logic [SAMPLE_WIDTH-1:0]     in_i,
  input  logic [SAMPLE_WIDTH-1:0]     in_q,
  output logic                        empty,
  input  logic                        pop,
  output logic [aed_pkg::AUDIO_W-1:0] audio
);

  import aed_pkg::*;

  localparam int MW = SAMPLE_WIDTH + 1;
  localparam int Q_DEPTH = 2;

  logic          in_ready;
  logic          f_valid;
  logic          f_ready;
  logic [MW-1:0] f_mag;
  logic          mq_full;
  logic          mq_empty;
  logic [MW-1:0] mq_data;
  logic          b_ready;
  logic          b_valid;
  logic [AUDIO_W-1:0] b_audio;
  logic          rq_full;

  assign full    = !in_ready;
  assign f_ready = !mq_full;

  aed_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (push),
    .in_ready (in_ready),
    .in_i     (in_i),
    .in_q     (in_q),
    .mag_valid(f_valid),
    .mag_ready(f_ready),
    .mag      (f_mag)
  );

  aed_fifo #(
    .WIDTH(MW),
    .DEPTH(Q_DEPTH)
  ) u_mag_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (f_valid),
    .wr_data(f_mag),
    .full   (mq_full),
    .rd_en  (b_ready),
    .rd_data(mq_data),
    .empty  (mq_empty)
  );

  aed_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .mag_valid  (!mq_empty),
    .mag_ready  (b_ready),
    .mag        (mq_data),
    .res_valid  (b_valid),
    .res_ready  (!rq_full),
    .res_audio  (b_audio)
  );

  aed_fifo #(
    .WIDTH(AUDIO_W),
    .DEPTH(Q_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (b_valid),
    .wr_data(b_audio),
    .full   (rq_full),
    .rd_en  (pop),
    .rd_data(audio),
    .empty  (empty)
  );

endmodule

/* rtl/aed_fifo.sv */
`timescale 1ns / 1ps

module aed_fifo #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/aed_front.sv */
`timescale 1ns / 1ps

module aed_front #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] in_i,
  input  logic [SAMPLE_WIDTH-1:0] in_q,
  output logic                    mag_valid,
  input  logic                    mag_ready,
  output logic [SAMPLE_WIDTH:0]   mag
);

  import aed_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int PROD_W = SW + COEF_W;
  localparam int SUM_W = PROD_W + 1;

  // stage 0: absolute values sorted into larger and smaller
  logic          v0;
  logic [SW-1:0] big;
  logic [SW-1:0] little;
  // stage 1: coefficient products
  logic              v1;
  logic [PROD_W-1:0] prod_a;
  logic [PROD_W-1:0] prod_b;
  // stage 2: rounded magnitude
  logic          v2;

  logic          rdy0;
  logic          rdy1;
  logic          rdy2;
  logic [SW:0]   neg_i;
  logic [SW:0]   neg_q;
  logic [SW-1:0] abs_i;
  logic [SW-1:0] abs_q;
  logic [SUM_W-1:0] sum;

  assign rdy2     = !v2 || mag_ready;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign in_ready = rdy0;

  always_comb begin
    neg_i = -{in_i[SW-1], in_i};
    neg_q = -{in_q[SW-1], in_q};
    abs_i = in_i[SW-1] ? neg_i[SW-1:0] : in_i;
    abs_q = in_q[SW-1] ? neg_q[SW-1:0] : in_q;
    sum   = {1'b0, prod_a} + {1'b0, prod_b} + SUM_W'(ROUND_HALF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy0) begin
        v0 <= in_valid;
      end
      if (rdy1) begin
        v1 <= v0;
      end
      if (rdy2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      if (abs_i > abs_q) begin
        big    <= abs_i;
        little <= abs_q;
      end else begin
        big    <= abs_q;
        little <= abs_i;
      end
    end
    if (rdy1 && v0) begin
      prod_a <= PROD_W'(big) * PROD_W'(ALPHA_Q16);
      prod_b <= PROD_W'(little) * PROD_W'(BETA_Q16);
    end
    if (rdy2 && v1) begin
      mag <= sum[SUM_W-1:COEF_W];
    end
  end

  assign mag_valid = v2;

endmodule

/* rtl/aed_back.sv */
`timescale 1ns / 1ps

module aed_back #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [aed_pkg::POLE_W-1:0]  cfg_wr_data,
  input  logic                        mag_valid,
  output logic                        mag_ready,
  input  logic [SAMPLE_WIDTH:0]       mag,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [aed_pkg::AUDIO_W-1:0] res_audio
);

  import aed_pkg::*;

  localparam int MW = SAMPLE_WIDTH + 1;
  localparam int YW = ((SAMPLE_WIDTH + 3) > 20) ? (SAMPLE_WIDTH + 3) : 20;
  localparam int PW = POLE_W + 1 + AUDIO_W;
  localparam logic signed [YW-1:0] Y_HI = YW'(AUDIO_MAX);
  localparam logic signed [YW-1:0] Y_LO = YW'(AUDIO_MIN);

  logic [POLE_W-1:0]         dc_pole;
  logic [MW-1:0]             prev_magnitude;
  logic signed [AUDIO_W-1:0] prev_audio;

  logic                      fire;
  logic signed [POLE_W:0]    pole_s;
  logic signed [PW-1:0]      fb_prod;
  logic signed [PW-1:0]      fb_rnd;
  logic signed [FB_W-1:0]    fb;
  logic signed [YW-1:0]      y_wide;
  logic signed [AUDIO_W-1:0] y;

  assign fire      = mag_valid && res_ready;
  assign mag_ready = res_ready;
  assign res_valid = mag_valid;
  assign res_audio = y;

  always_comb begin
    pole_s  = $signed({1'b0, dc_pole});
    fb_prod = PW'(pole_s) * PW'(prev_audio);
    fb_rnd  = fb_prod + PW'(ROUND_HALF);
    fb      = fb_rnd[PW-1:COEF_W];
    y_wide  = $signed({{(YW-MW){1'b0}}, mag})
            - $signed({{(YW-MW){1'b0}}, prev_magnitude})
            + $signed({{(YW-FB_W){fb[FB_W-1]}}, fb});
    priority if (y_wide > Y_HI) begin
      y = Y_HI[AUDIO_W-1:0];
    end else if (y_wide < Y_LO) begin
      y = Y_LO[AUDIO_W-1:0];
    end else begin
      y = y_wide[AUDIO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dc_pole        <= POLE_RESET;
      prev_magnitude <= '0;
      prev_audio     <= '0;
    end else begin
      if (cfg_wr_en) begin
        dc_pole <= cfg_wr_data;
      end
      if (fire) begin
        prev_magnitude <= mag;
        prev_audio     <= y;
      end
    end
  end

endmodule

/* rtl/aed_checker.sv */
`timescale 1ns / 1ps

module aed_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic [aed_pkg::AUDIO_W-1:0] audio
);

  // a result waiting and not taken stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(audio)))
    else $error("waiting result changed or vanished");

  // pipeline depth: the result queue stays empty after reset while a first request passes the pipeline
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> empty ##1 empty ##1 empty ##1 empty)
    else $error("result appeared too soon after reset");

  // an empty result queue means the back end is draining, so input is open
  a_no_false_full: assert property (@(posedge clk) disable iff (rst)
    empty |-> !full)
    else $error("input blocked while result queue empty");

  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("queues not cleared by reset");

endmodule

bind am_envelope_dc_block_core aed_checker u_aed_checker (
  .clk  (clk),
  .rst  (rst),
  .full (full),
  .empty(empty),
  .pop  (pop),
  .audio(audio)
);
